FILE: hdl/lats_pkg.sv
// ----------------------------------------------------------------------------
// lats_pkg
// Shared types, constants and helper functions of the look-at to spherical
// converter.
// ----------------------------------------------------------------------------
package lats_pkg;

  localparam int DW        = 62;   // CORDIC datapath width, signed
  localparam int ZW        = 35;   // angle accumulator width, signed Q.30
  localparam int DIFF_W    = 33;   // exact coordinate difference
  localparam int GUARD_BITS = 24;
  localparam int ACC_BITS  = 30;
  localparam int YAW_W     = 19;
  localparam int PITCH_W   = 18;
  localparam int DIST_W    = 33;
  localparam int LIMIT_W   = 17;

  typedef logic signed [DW-1:0]     dp_t;
  typedef logic signed [ZW-1:0]     ang_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SAME     = 2'd1,
    ST_POLE     = 2'd2,
    ST_RESERVED = 2'd3
  } status_t;

  localparam logic [29:0]        INV_GAIN    = 30'd652032874;
  localparam ang_t               PI_Q30      = ang_t'(64'sd3373259426);
  localparam ang_t               HALF_PI_Q30 = ang_t'(64'sd1686629713);
  localparam logic [LIMIT_W-1:0] POLE_RESET  = 17'd102933;
  localparam logic [DIST_W-1:0]  DIST_MAX    = {DIST_W{1'b1}};

  // atan(2^-i) in Q2.30, truncated.
  localparam longint ATAN_TAB [0:31] = '{
    843314856, 497837829, 263043836, 133525158,
    67021686, 33543515, 16775850, 8388437,
    4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767,
    16383, 8191, 4095, 2047,
    1023, 511, 255, 127,
    63, 31, 15, 7,
    3, 1, 0, 0
  };

  // Saturates a Q.30 angle to +-lim, then rounds to (30 - sh) fraction bits,
  // half away from zero.
  function automatic ang_t angle_round(input ang_t z, input ang_t lim,
                                       input int unsigned sh);
    ang_t zs;
    ang_t half;
    ang_t m;
    half = ang_t'(1) <<< (sh - 1);
    if (z > lim) zs = lim;
    else if (z < -lim) zs = -lim;
    else zs = z;
    if (!zs[ZW-1]) return (zs + half) >>> sh;
    m = (-zs + half) >>> sh;
    return -m;
  endfunction

endpackage

FILE: hdl/lats_cordic_stage.sv
// ----------------------------------------------------------------------------
// lats_cordic_stage
// One registered CORDIC vectoring iteration with a side payload that
// travels alongside.
// ----------------------------------------------------------------------------
module lats_cordic_stage import lats_pkg::*; #(
  parameter int SHIFT  = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  input  dp_t               x_i,
  input  dp_t               y_i,
  input  ang_t              z_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output dp_t               x_o,
  output dp_t               y_o,
  output ang_t              z_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam ang_t STEP = ang_t'(ATAN_TAB[SHIFT]);

  logic              valid_r;
  dp_t               x_r, x_nxt;
  dp_t               y_r, y_nxt;
  ang_t              z_r, z_nxt;
  logic [SIDE_W-1:0] side_r;

  always_comb begin
    if (!y_i[DW-1]) begin
      x_nxt = x_i + (y_i >>> SHIFT);
      y_nxt = y_i - (x_i >>> SHIFT);
      z_nxt = z_i + STEP;
    end else begin
      x_nxt = x_i - (y_i >>> SHIFT);
      y_nxt = y_i + (x_i >>> SHIFT);
      z_nxt = z_i - STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_i;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    side_r <= side_i;
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign side_o  = side_r;

endmodule

FILE: hdl/lats_gain.sv
// ----------------------------------------------------------------------------
// lats_gain
// Two-stage CORDIC gain correction: round(a * INV_GAIN / 2^30), half up,
// built from two narrow partial products.
// ----------------------------------------------------------------------------
module lats_gain import lats_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  input  logic [DW-1:0]     a_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [DW-1:0]     gf_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int HI_W = DW - ACC_BITS;

  logic              v1_r, v2_r;
  logic [DW-1:0]     p_hi_r, p_hi_nxt;
  logic [DW-1:0]     p_lo_r, p_lo_nxt;
  logic [DW-1:0]     gf_r, gf_nxt;
  logic [SIDE_W-1:0] s1_r, s2_r;
  logic [HI_W-1:0]   hi;
  logic [ACC_BITS-1:0] lo;

  assign hi = a_i[DW-1:ACC_BITS];
  assign lo = a_i[ACC_BITS-1:0];

  always_comb begin
    p_hi_nxt = DW'(hi) * DW'(INV_GAIN);
    p_lo_nxt = DW'(lo) * DW'(INV_GAIN) + (DW'(1) << (ACC_BITS - 1));
    gf_nxt   = p_hi_r + (p_lo_r >> ACC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
    p_hi_r <= p_hi_nxt;
    p_lo_r <= p_lo_nxt;
    s1_r   <= side_i;
    gf_r   <= gf_nxt;
    s2_r   <= s1_r;
  end

  assign valid_o = v2_r;
  assign gf_o    = gf_r;
  assign side_o  = s2_r;

endmodule

FILE: hdl/look_at_to_spherical_core.sv
// ----------------------------------------------------------------------------
// look_at_to_spherical_core
// Eye/target pair to distance, yaw and pitch through two chained pipelined
// CORDIC vectoring passes.
// ----------------------------------------------------------------------------
// A transaction is taken in every cycle that start is high; busy is always
// low. Each transaction yields one result, in order, held on the out_ ports
// with out_valid for one cycle. Between the edge that took the transaction
// and the result lie, in order, the offset and half-plane fold registers,
// the pass-1 CORDIC chain of one stage per iteration, the horizontal gain
// multiplier, the pass-2 entry register, the pass-2 CORDIC chain, the full
// radius gain multiplier, and the rounding and output registers. The
// receiver cannot stall the pipeline.
module look_at_to_spherical_core import lats_pkg::*; #(
  parameter int CORDIC_STAGES = 18,
  parameter int FRAC_BITS     = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [31:0]        in_eye_x,
  input  logic signed [31:0]        in_eye_y,
  input  logic signed [31:0]        in_eye_z,
  input  logic signed [31:0]        in_target_x,
  input  logic signed [31:0]        in_target_y,
  input  logic signed [31:0]        in_target_z,
  input  logic                      cfg_we,
  input  logic [LIMIT_W-1:0]        cfg_wdata,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [DIST_W-1:0]         out_distance,
  output logic signed [YAW_W-1:0]   out_yaw_angle,
  output logic signed [PITCH_W-1:0] out_pitch_angle
);

  localparam int NST = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int SH  = ACC_BITS - FRAC_BITS;
  localparam int LAT = 2 * NST + 9;
  localparam int S1W = 1 + DIFF_W;
  localparam int G1W = ZW + DIFF_W + 1;
  localparam int S2W = 1 + YAW_W;
  localparam int G2W = ZW + YAW_W + 1;

  assign busy = 1'b0;

  // Pole limit register.
  logic [LIMIT_W-1:0] limit_r;
  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= POLE_RESET;
    else if (cfg_we) limit_r <= cfg_wdata;
  end

  // Stage 0: exact offsets.
  logic  v0_r;
  diff_t dx_r, dy_r, dz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else v0_r <= start;
    dx_r <= diff_t'(in_eye_x) - diff_t'(in_target_x);
    dy_r <= diff_t'(in_eye_y) - diff_t'(in_target_y);
    dz_r <= diff_t'(in_eye_z) - diff_t'(in_target_z);
  end

  // Stage 1: guard shift and left half-plane fold.
  logic [S1W-1:0] p1_s [0:NST];
  dp_t            p1_x [0:NST];
  dp_t            p1_y [0:NST];
  ang_t           p1_z [0:NST];
  logic           p1_v [0:NST];
  dp_t            x0_nxt, y0_nxt;
  ang_t           z0_nxt;
  logic           same;

  assign same = (dx_r == '0) && (dy_r == '0) && (dz_r == '0);

  always_comb begin
    x0_nxt = dp_t'(dz_r) <<< GUARD_BITS;
    y0_nxt = dp_t'(dx_r) <<< GUARD_BITS;
    z0_nxt = '0;
    if (dz_r[DIFF_W-1]) begin
      x0_nxt = -x0_nxt;
      y0_nxt = -y0_nxt;
      z0_nxt = dx_r[DIFF_W-1] ? -PI_Q30 : PI_Q30;
    end
  end

  logic           v1_r;
  dp_t            x1_r, y1_r;
  ang_t           z1_r;
  logic [S1W-1:0] s1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= v0_r;
    x1_r <= x0_nxt;
    y1_r <= y0_nxt;
    z1_r <= z0_nxt;
    s1_r <= {same, dy_r};
  end

  assign p1_v[0] = v1_r;
  assign p1_x[0] = x1_r;
  assign p1_y[0] = y1_r;
  assign p1_z[0] = z1_r;
  assign p1_s[0] = s1_r;

  genvar gi;
  generate
    for (gi = 0; gi < NST; gi++) begin : g_pass1
      lats_cordic_stage #(.SHIFT(gi), .SIDE_W(S1W)) u_stage (
        .clk(clk), .rst_n(rst_n),
        .valid_i(p1_v[gi]), .x_i(p1_x[gi]), .y_i(p1_y[gi]), .z_i(p1_z[gi]),
        .side_i(p1_s[gi]),
        .valid_o(p1_v[gi+1]), .x_o(p1_x[gi+1]), .y_o(p1_y[gi+1]),
        .z_o(p1_z[gi+1]), .side_o(p1_s[gi+1])
      );
    end
  endgenerate

  // Horizontal radius gain correction.
  logic           g1_v;
  logic [DW-1:0]  g1_gf;
  logic [G1W-1:0] g1_s;
  lats_gain #(.SIDE_W(G1W)) u_gain_h (
    .clk(clk), .rst_n(rst_n),
    .valid_i(p1_v[NST]), .a_i(p1_x[NST]),
    .side_i({p1_z[NST], p1_s[NST]}),
    .valid_o(g1_v), .gf_o(g1_gf), .side_o(g1_s)
  );

  // Pass 2 entry: yaw rounding and vertical vector set-up.
  ang_t  yaw_full;
  diff_t g1_dy;
  logic  g1_same;
  assign g1_dy    = g1_s[DIFF_W-1:0];
  assign g1_same  = g1_s[DIFF_W];
  assign yaw_full = angle_round(g1_s[G1W-1:DIFF_W+1], PI_Q30, SH);

  logic [S2W-1:0] p2_s [0:NST];
  dp_t            p2_x [0:NST];
  dp_t            p2_y [0:NST];
  ang_t           p2_z [0:NST];
  logic           p2_v [0:NST];

  logic           v2_r;
  dp_t            x2_r, y2_r;
  logic [S2W-1:0] s2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= g1_v;
    x2_r <= dp_t'(g1_gf);
    y2_r <= dp_t'(g1_dy) <<< GUARD_BITS;
    s2_r <= {g1_same, yaw_full[YAW_W-1:0]};
  end

  assign p2_v[0] = v2_r;
  assign p2_x[0] = x2_r;
  assign p2_y[0] = y2_r;
  assign p2_z[0] = '0;
  assign p2_s[0] = s2_r;

  generate
    for (gi = 0; gi < NST; gi++) begin : g_pass2
      lats_cordic_stage #(.SHIFT(gi), .SIDE_W(S2W)) u_stage (
        .clk(clk), .rst_n(rst_n),
        .valid_i(p2_v[gi]), .x_i(p2_x[gi]), .y_i(p2_y[gi]), .z_i(p2_z[gi]),
        .side_i(p2_s[gi]),
        .valid_o(p2_v[gi+1]), .x_o(p2_x[gi+1]), .y_o(p2_y[gi+1]),
        .z_o(p2_z[gi+1]), .side_o(p2_s[gi+1])
      );
    end
  endgenerate

  // Full radius gain correction.
  logic           g2_v;
  logic [DW-1:0]  g2_gf;
  logic [G2W-1:0] g2_s;
  lats_gain #(.SIDE_W(G2W)) u_gain_d (
    .clk(clk), .rst_n(rst_n),
    .valid_i(p2_v[NST]), .a_i(p2_x[NST]),
    .side_i({p2_z[NST], p2_s[NST]}),
    .valid_o(g2_v), .gf_o(g2_gf), .side_o(g2_s)
  );

  // Stage E: pitch and distance rounding.
  logic [DW-1:0]     dist_sum;
  logic              ve_r;
  ang_t              pitch_r;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic [YAW_W-1:0]  yaw_e_r;
  logic              same_e_r;

  assign dist_sum = (g2_gf + (DW'(1) << (GUARD_BITS - 1))) >> GUARD_BITS;
  assign dist_nxt = (dist_sum > DW'(DIST_MAX)) ? DIST_MAX : dist_sum[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) ve_r <= 1'b0;
    else ve_r <= g2_v;
    pitch_r  <= angle_round(g2_s[G2W-1:S2W], HALF_PI_Q30, SH);
    dist_r   <= dist_nxt;
    yaw_e_r  <= g2_s[YAW_W-1:0];
    same_e_r <= g2_s[YAW_W];
  end

  // Stage F: rejection and output register.
  ang_t    pitch_mag;
  status_t status_nxt;
  assign pitch_mag = pitch_r[ZW-1] ? -pitch_r : pitch_r;

  always_comb begin
    priority if (same_e_r) status_nxt = ST_SAME;
    else if (pitch_mag > ang_t'(limit_r)) status_nxt = ST_POLE;
    else status_nxt = ST_OK;
  end

  logic                      out_valid_r;
  logic [1:0]                status_r;
  logic [DIST_W-1:0]         distance_r;
  logic signed [YAW_W-1:0]   yaw_r;
  logic signed [PITCH_W-1:0] pitch_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= ve_r;
    status_r <= status_nxt;
    if (status_nxt == ST_OK) begin
      distance_r  <= dist_r;
      yaw_r       <= yaw_e_r;
      pitch_out_r <= pitch_r[PITCH_W-1:0];
    end else begin
      distance_r  <= '0;
      yaw_r       <= '0;
      pitch_out_r <= '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_distance    = distance_r;
  assign out_yaw_angle   = yaw_r;
  assign out_pitch_angle = pitch_out_r;

  // Every accepted transaction is checked to reach the output with out_valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid)
    else $error("transaction did not reach the output");

  // A rejected result carries no numbers.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_distance == '0 && out_yaw_angle == '0 && out_pitch_angle == '0))
    else $error("rejected result has nonzero fields");

  // The reserved status code never leaves the block.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != ST_RESERVED)
    else $error("reserved status code");

  // An accepted pitch never exceeds the limit in force.
  a_pitch_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK && !out_pitch_angle[PITCH_W-1]) |->
      (PITCH_W'(limit_r) >= out_pitch_angle || limit_r[LIMIT_W-1]))
    else $error("accepted pitch beyond pole limit");

endmodule
